[hdl/cbpe_pkg.sv]
// Shared constants and types for the cubic Bezier point evaluator.
`default_nettype none

package cbpe_pkg;

   // Field formats
   localparam int COORD_BITS      = 16;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_BITS      = PARAM_FRAC_BITS + 2;
   localparam int NUM_POINTS      = 4;
   localparam int NUM_AXES        = 3;
   localparam int POINT_BITS      = NUM_AXES * COORD_BITS;

   // Internal widths
   localparam int T_BITS    = PARAM_FRAC_BITS + 1;        // 0 .. 2^F
   localparam int WGT_BITS  = PARAM_FRAC_BITS + 4;        // signed weights
   localparam int PROD_BITS = WGT_BITS + COORD_BITS;
   localparam int ACC_BITS  = PROD_BITS + 2;              // sum of four products
   localparam int RND_BITS  = ACC_BITS - PARAM_FRAC_BITS; // after the rounding shift

   // Stream widths, padded to whole bytes
   localparam int REQ_DATA_BITS  = ((PARAM_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((NUM_AXES * COORD_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 2;

   // Register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_POINT_ZERO  = 2'd0,
      REG_POINT_ONE   = 2'd1,
      REG_POINT_TWO   = 2'd2,
      REG_POINT_THREE = 2'd3
   } csr_index_type;

   typedef logic [T_BITS-1:0]          t_type;
   typedef logic signed [WGT_BITS-1:0] wgt_type;
   typedef logic [POINT_BITS-1:0]      point_type;

   // Bernstein weights of one item with its valid bit
   typedef struct packed {
      logic    valid;
      wgt_type w0;
      wgt_type w1;
      wgt_type w2;
      wgt_type w3;
   } weight_bus_type;

   // The four control points
   typedef struct packed {
      point_type p0;
      point_type p1;
      point_type p2;
      point_type p3;
   } ctrl_points_type;

endpackage

`default_nettype wire

[hdl/cbpe_power.sv]
// Clamp of t, power vector and basis matrix: four pipeline stages to the weights.
`default_nettype none

module cbpe_power (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [cbpe_pkg::PARAM_BITS-1:0]      in_param,
   output cbpe_pkg::weight_bus_type             wgt
);
   import cbpe_pkg::*;

   localparam t_type T_ONE = t_type'(1) << PARAM_FRAC_BITS;
   localparam logic [2*T_BITS-1:0] HALF_SQ = (2*T_BITS)'(1) << (PARAM_FRAC_BITS - 1);
   localparam wgt_type W_ONE = wgt_type'(1) << PARAM_FRAC_BITS;

   logic va_ff, vb_ff, vc_ff, vd_ff;
   t_type t_a_ff, t_a_in;
   t_type t_b_ff, t2_b_ff, t2_b_in;
   t_type t_c_ff, t2_c_ff, t3_c_ff, t3_c_in;
   wgt_type w0_ff, w1_ff, w2_ff, w3_ff;
   wgt_type w0_in, w1_in, w2_in, w3_in;
   wgt_type p1w, p2w, p3w;
   logic [2*T_BITS-1:0] sq, cu;

   // Stage A: clamp t to 0 .. 1
   always_comb begin
      if (in_param[PARAM_BITS-1]) begin
         t_a_in = '0;
      end else if (in_param[PARAM_BITS-2:0] > T_ONE) begin
         t_a_in = T_ONE;
      end else begin
         t_a_in = in_param[T_BITS-1:0];
      end
   end

   // Stage B: t^2, rounded half up
   assign sq      = t_a_ff * t_a_ff + HALF_SQ;
   assign t2_b_in = sq[PARAM_FRAC_BITS +: T_BITS];

   // Stage C: t^3 from t^2 and t
   assign cu      = t2_b_ff * t_b_ff + HALF_SQ;
   assign t3_c_in = cu[PARAM_FRAC_BITS +: T_BITS];

   // Stage D: power vector times basis matrix
   always_comb begin
      p1w   = wgt_type'({{(WGT_BITS-T_BITS){1'b0}}, t_c_ff});
      p2w   = wgt_type'({{(WGT_BITS-T_BITS){1'b0}}, t2_c_ff});
      p3w   = wgt_type'({{(WGT_BITS-T_BITS){1'b0}}, t3_c_ff});
      w0_in = W_ONE - p3w + (p2w <<< 1) + p2w - (p1w <<< 1) - p1w;
      w1_in = (p3w <<< 1) + p3w - (p2w <<< 2) - (p2w <<< 1) + (p1w <<< 1) + p1w;
      w2_in = (p2w <<< 1) + p2w - (p3w <<< 1) - p3w;
      w3_in = p3w;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         t_a_ff  <= t_a_in;
         t_b_ff  <= t_a_ff;
         t2_b_ff <= t2_b_in;
         t_c_ff  <= t_b_ff;
         t2_c_ff <= t2_b_ff;
         t3_c_ff <= t3_c_in;
         w0_ff   <= w0_in;
         w1_ff   <= w1_in;
         w2_ff   <= w2_in;
         w3_ff   <= w3_in;
      end
   end

   assign wgt.valid = vd_ff;
   assign wgt.w0    = w0_ff;
   assign wgt.w1    = w1_ff;
   assign wgt.w2    = w2_ff;
   assign wgt.w3    = w3_ff;

   // Clamped t never exceeds one
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      va_ff |-> (t_a_ff <= T_ONE))
      else $error("clamped parameter above one");

   // Bernstein weights are a partition of unity
   a_unity: assert property (@(posedge clock) disable iff (reset)
      vd_ff |-> (wgt_type'(w0_ff + w1_ff + w2_ff + w3_ff) == W_ONE))
      else $error("weights do not sum to one");

   // A stall freezes the valid bits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({va_ff, vb_ff, vc_ff, vd_ff}))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[hdl/cbpe_blend.sv]
// Weighted blend of the control points: products, sums, rounding and saturation.
`default_nettype none

module cbpe_blend (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  cbpe_pkg::weight_bus_type             wgt,
   input  cbpe_pkg::ctrl_points_type            ctrl,
   output logic                                 out_valid,
   output logic [cbpe_pkg::RSP_DATA_BITS-1:0]   out_data
);
   import cbpe_pkg::*;

   localparam logic signed [ACC_BITS-1:0] HALF_ACC =
      ACC_BITS'(1) << (PARAM_FRAC_BITS - 1);
   localparam logic signed [RND_BITS-1:0] COORD_MAX =
      RND_BITS'((1 << (COORD_BITS - 1)) - 1);
   localparam logic signed [RND_BITS-1:0] COORD_MIN =
      -RND_BITS'(1 << (COORD_BITS - 1));

   logic ve_ff, vf_ff, vg_ff;
   logic signed [PROD_BITS-1:0] prod_ff [NUM_AXES][NUM_POINTS];
   logic signed [PROD_BITS-1:0] prod_in [NUM_AXES][NUM_POINTS];
   logic signed [ACC_BITS-1:0]  acc_ff [NUM_AXES];
   logic signed [ACC_BITS-1:0]  acc_in [NUM_AXES];
   logic signed [ACC_BITS-1:0]  rnd [NUM_AXES];
   logic signed [RND_BITS-1:0]  shr [NUM_AXES];
   logic [COORD_BITS-1:0]       pos_ff [NUM_AXES];
   logic [COORD_BITS-1:0]       pos_in [NUM_AXES];

   // Stage E: one product per axis and control point
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_in[a][0] = wgt.w0 * $signed(ctrl.p0[a*COORD_BITS +: COORD_BITS]);
         prod_in[a][1] = wgt.w1 * $signed(ctrl.p1[a*COORD_BITS +: COORD_BITS]);
         prod_in[a][2] = wgt.w2 * $signed(ctrl.p2[a*COORD_BITS +: COORD_BITS]);
         prod_in[a][3] = wgt.w3 * $signed(ctrl.p3[a*COORD_BITS +: COORD_BITS]);
      end
   end

   // Stage F: sum of the four products
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         acc_in[a] = ACC_BITS'(prod_ff[a][0]) + ACC_BITS'(prod_ff[a][1])
                   + ACC_BITS'(prod_ff[a][2]) + ACC_BITS'(prod_ff[a][3]);
      end
   end

   // Stage G: round half up, then saturate to the coordinate range
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         rnd[a] = acc_ff[a] + HALF_ACC;
         shr[a] = rnd[a][ACC_BITS-1:PARAM_FRAC_BITS];
         if (shr[a] > COORD_MAX) begin
            pos_in[a] = COORD_MAX[COORD_BITS-1:0];
         end else if (shr[a] < COORD_MIN) begin
            pos_in[a] = COORD_MIN[COORD_BITS-1:0];
         end else begin
            pos_in[a] = shr[a][COORD_BITS-1:0];
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= wgt.valid;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
      end
   end

   assign out_valid = vg_ff;
   assign out_data  = RSP_DATA_BITS'({pos_ff[2], pos_ff[1], pos_ff[0]});

endmodule

`default_nettype wire

[hdl/cubic_bezier_point_eval.sv]
// Cubic Bezier point evaluator: top level with control point registers.
//
// Channels: req_* carries one curve parameter t (signed Q2.16) per item;
// rsp_* returns the curve point (x, y, z, signed 16 bit each) per item, in
// order. csr_* writes the four control points by index 0..3; csr_ready is
// always high. Write control points only while no item is in flight.
//
// Seven register stages: clamp, t^2, t^3, basis matrix, products, sum,
// round/saturate. Throughput is one item per cycle while the receiver
// does not stall the output; each stage holds one multiply or a short
// adder chain.
//
// Reset clears all valid bits and the control points to zero.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; empty slots do not block, so the
// block keeps taking items as long as rsp_tvalid is low.
`default_nettype none

module cubic_bezier_point_eval (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input items; tdata: curve_param [17:0], zero padding above
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [cbpe_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // Result items; tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cbpe_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // Control point writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cbpe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cbpe_pkg::POINT_BITS-1:0]        csr_data
);
   import cbpe_pkg::*;

   logic            en;
   ctrl_points_type ctrl_ff, ctrl_in;
   weight_bus_type  wgt;

   // Pipeline advances unless a result is waiting on the receiver
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // Control point registers
   always_comb begin
      ctrl_in = ctrl_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_POINT_ZERO:  ctrl_in.p0 = csr_data;
            REG_POINT_ONE:   ctrl_in.p1 = csr_data;
            REG_POINT_TWO:   ctrl_in.p2 = csr_data;
            REG_POINT_THREE: ctrl_in.p3 = csr_data;
            default:         ctrl_in = ctrl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Weights
   cbpe_power u_power (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_param (req_tdata[PARAM_BITS-1:0]),
      .wgt      (wgt)
   );

   // Blend and output register
   cbpe_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .wgt       (wgt),
      .ctrl      (ctrl_ff),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

[test/cubic_bezier_point_eval_tb.sv]
// Self-checking testbench for the cubic Bezier point evaluator.
`default_nettype none

module cubic_bezier_point_eval_tb;
   import cbpe_pkg::*;

   localparam longint UNIT        = longint'(1) << PARAM_FRAC_BITS;
   localparam longint HALF_UNIT   = UNIT / 2;
   localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN   = -(longint'(1) << (COORD_BITS - 1));
   localparam int PIPE_LATENCY    = 7;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 290;
   localparam int REPORT_LIMIT    = 10;

   // One curve point; x sits in the low bits as on rsp_tdata
   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } curve_point_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_PULSED} ready_mode_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index  = REG_POINT_ZERO;
   logic [POINT_BITS-1:0]     csr_data   = '0;

   // Shadow copy of the control points, updated on accepted writes
   point_type ctrl_points [NUM_POINTS] = '{default: '0};

   logic [PARAM_BITS-1:0] param_queue [$];
   curve_point_type       expected_points [$];
   bit                    item_taken   = 1'b0;
   bit                    write_taken  = 1'b0;
   int                    mismatch_count = 0;
   int                    cycle_count    = 0;
   int                    burst_left     = 0;
   int                    gap_left       = 0;
   int                    stall_left     = 0;
   ready_mode_type        stall_mode     = READY_ALWAYS;

   cubic_bezier_point_eval uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Blend the control points for one curve parameter
   function automatic curve_point_type predict_point(logic [PARAM_BITS-1:0] param);
      longint t, t2, t3, acc, v;
      longint wgt [NUM_POINTS];
      logic signed [COORD_BITS-1:0] coord [NUM_AXES];
      logic signed [COORD_BITS-1:0] c;
      curve_point_type pt;
      t = longint'($signed(param));
      if (t < 0) t = 0;
      if (t > UNIT) t = UNIT;
      t2 = (t * t + HALF_UNIT) >>> PARAM_FRAC_BITS;
      t3 = (t2 * t + HALF_UNIT) >>> PARAM_FRAC_BITS;
      wgt[0] = -t3 + 3 * t2 - 3 * t + UNIT;
      wgt[1] = 3 * t3 - 6 * t2 + 3 * t;
      wgt[2] = -3 * t3 + 3 * t2;
      wgt[3] = t3;
      for (int a = 0; a < NUM_AXES; a++) begin
         acc = 0;
         for (int i = 0; i < NUM_POINTS; i++) begin
            c = ctrl_points[i][a * COORD_BITS +: COORD_BITS];
            acc += wgt[i] * longint'(c);
         end
         // round half up, then clip to the coordinate range
         v = (acc + HALF_UNIT) >>> PARAM_FRAC_BITS;
         if (v > COORD_MAX) v = COORD_MAX;
         if (v < COORD_MIN) v = COORD_MIN;
         coord[a] = v[COORD_BITS-1:0];
      end
      pt.x = coord[0];
      pt.y = coord[1];
      pt.z = coord[2];
      return pt;
   endfunction

   // Mostly inside 0..1, with corners and the full signed range mixed in
   function automatic logic [PARAM_BITS-1:0] random_param();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3)
         return PARAM_BITS'($urandom());
      if (pick == 3)
         return PARAM_BITS'(int'($urandom_range(0, 4)) - 2);
      if (pick == 4)
         return PARAM_BITS'(UNIT + longint'($urandom_range(0, 4)) - 2);
      return PARAM_BITS'($urandom_range(0, 32'(UNIT)));
   endfunction

   function automatic logic [COORD_BITS-1:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return COORD_BITS'(COORD_MAX);
      if (pick == 1) return COORD_BITS'(COORD_MIN);
      return COORD_BITS'($urandom());
   endfunction

   task automatic write_point(csr_index_type idx, point_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!write_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic load_points(point_type p0, point_type p1, point_type p2, point_type p3);
      write_point(REG_POINT_ZERO, p0);
      write_point(REG_POINT_ONE, p1);
      write_point(REG_POINT_TWO, p2);
      write_point(REG_POINT_THREE, p3);
      @(posedge clock);
   endtask

   // Block is idle once every item went in and every result came back
   task automatic wait_drained();
      do @(negedge clock);
      while (param_queue.size() != 0 || req_tvalid || expected_points.size() != 0);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   // Parameter driver: bursts of items with random gaps in between
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || item_taken) begin
         if (gap_left > 0 || param_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_BITS'(param_queue.pop_front());
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   // Result stalls: switch between always ready, coin flips and a fixed pulse
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(16, 80);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= (stall_left % 5) < 2;
         end
      endcase
   end

   // Monitor: track handshakes, predict on accept, check results in order
   always @(posedge clock) begin
      curve_point_type got;
      curve_point_type want;
      if (reset) begin
         item_taken  = 1'b0;
         write_taken = 1'b0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("cubic_bezier_point_eval regression: fail");
         $finish;
      end else begin
         cycle_count++;
         write_taken = csr_valid && csr_ready;
         if (write_taken)
            ctrl_points[csr_index] = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = curve_point_type'(rsp_tdata[POINT_BITS-1:0]);
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                              want.x, want.y, want.z, got.x, got.y, got.z);
               end
            end
         end
         item_taken = req_tvalid && req_tready;
         if (item_taken)
            expected_points.push_back(predict_point(req_tdata[PARAM_BITS-1:0]));
      end
   end

   // Stimulus: directed corners, then random phases over several point sets
   initial begin
      static int corner_params [17] = '{-131072, -65536, -1, 0, 1, 2, 255, 256, 32767,
                                        32768, 32769, 65534, 65535, 65536, 65537,
                                        100000, 131071};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // control points still at their reset value
      @(posedge clock);
      param_queue.push_back(PARAM_BITS'(0));
      param_queue.push_back(PARAM_BITS'(HALF_UNIT));
      param_queue.push_back(PARAM_BITS'(UNIT));
      wait_drained();

      // distinct points with extreme coordinates, parameter corners
      load_points({16'h0000, 16'h7FFF, 16'h8000}, {16'h03E8, 16'h8000, 16'h7FFF},
                  {16'h8000, 16'h3039, 16'hFFFF}, {16'hFFFF, 16'h8000, 16'h7FFF});
      foreach (corner_params[i])
         param_queue.push_back(PARAM_BITS'(corner_params[i]));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         if (ph == 0) begin
            load_points({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
         end else if (ph == 1) begin
            load_points({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
         end else begin
            load_points({random_coord(), random_coord(), random_coord()},
                        {random_coord(), random_coord(), random_coord()},
                        {random_coord(), random_coord(), random_coord()},
                        {random_coord(), random_coord(), random_coord()});
         end
         repeat (ITEMS_PER_PHASE)
            param_queue.push_back(random_param());
      end

      wait_drained();
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("cubic_bezier_point_eval regression: pass");
      end else begin
         $display("cubic_bezier_point_eval regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
